// ===== rtl/iir_threshold_rate_meter_assert.svh =====
// Assertion macros for the IIR threshold rate meter checker.
`ifndef IIR_THRESHOLD_RATE_METER_ASSERT_SVH
`define IIR_THRESHOLD_RATE_METER_ASSERT_SVH

// Clocked on clk, muted while rst is high.
`define ITRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked during reset.
`define ITRM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/itrm_pkg.sv =====
// Types and constants for the IIR threshold rate meter.
`default_nettype none
package itrm_pkg;

  // Accumulator of the serial MAC: holds A1*y1 - A2*y2 + X*2^16 (< 2^49).
  localparam int ACC_W = 52;

  localparam logic signed [ACC_W-1:0] COEF_A1  = 52'sd108528;
  localparam logic signed [ACC_W-1:0] COEF_A2  = 52'sd44951;
  localparam logic signed [ACC_W-1:0] COEF_B0  = 52'sd1028;
  localparam logic signed [ACC_W-1:0] COEF_B1  = 52'sd906;
  localparam logic signed [ACC_W-1:0] ROUND_Y  = 52'sd32768;

  localparam logic [23:0] RATE_NUM      = 24'd15360000;
  localparam logic [15:0] THRESH_RESET  = 16'd8960;
  localparam logic [7:0]  FAULT_RESET   = 8'd200;

  localparam logic [4:0]  MAC_LAST_BIT  = 5'd31;
  localparam logic [4:0]  DIV_LAST_BIT  = 5'd23;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_FAULT     = 1'b1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_CROSS,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/iir_threshold_rate_meter.sv =====
// Top level: serial second-order IIR low-pass with threshold crossing rate meter.
// A beat steps through the 32-step bit-serial MAC loop, ROUND, CROSS, the 24-step
// restoring divider when a rising crossing with a nonzero period starts a rate
// division, and EMIT; s_tready is high only in IDLE, so beats do not overlap.
// The output register frees the input side while a result beat waits.
// Reset (rst, synchronous): filter state cleared, above flag set, rate zero,
// threshold 35 mm and fault distance 200 mm.
`default_nettype none
module iir_threshold_rate_meter
  import itrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config write port
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [15:0]           cfg_data,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] range_mm, [39:8] time_ms
  input  wire logic                  s_tuser,   // [0] sample_ok
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // [17:0] filtered_q8, [41:18] rate_q8,
                                                // [47:42] zero
);

  state_t state, state_next;

  // config registers
  logic [15:0] threshold_q8;
  logic [7:0]  fault_distance;

  // architectural state
  logic [7:0]         prev_sample;
  logic signed [31:0] out_prev1;
  logic signed [31:0] out_prev2;
  logic               above_flag;
  logic [31:0]        last_cross_time;
  logic [31:0]        first_half_period;
  logic [23:0]        rate_reg;

  // working registers of one beat
  logic [7:0]             x_cur;
  logic [31:0]            now_ms;
  logic [31:0]            sh_y1, sh_y2;   // MSB-first multiplicand shifters
  logic [7:0]             sh_x, sh_x1;
  logic signed [ACC_W-1:0] acc;
  logic [4:0]             cnt;
  logic [17:0]            filt;
  logic [32:0]            rem;
  logic [32:0]            divisor;
  logic [23:0]            quo;            // dividend bits out the top, quotient in

  logic                   out_valid;
  logic [OUT_DATA_W-1:0]  out_data;

  logic                   load_out;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // ---------------------------------------------------------------------------
  // Serial MAC step: acc = 2*acc + A1*y1[i] - A2*y2[i] (+ B terms at i = 16..23).
  // Bit 31 of y carries weight -2^31, so its term is negated.
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] term_a, term_b, acc_next;
  logic                    x_window;

  assign x_window = cnt[4] & ~cnt[3];

  always_comb begin
    term_a = (sh_y1[31] ? COEF_A1 : '0) - (sh_y2[31] ? COEF_A2 : '0);
    if (cnt == MAC_LAST_BIT) begin
      term_a = -term_a;
    end
    term_b = '0;
    if (x_window) begin
      term_b = (sh_x[7] ? COEF_B0 : '0) + (sh_x1[7] ? COEF_B1 : '0);
    end
    acc_next = (acc <<< 1) + term_a + term_b;
  end

  // Round half up to Q16 and saturate to 32 bits.
  logic signed [ACC_W-1:0] acc_rnd;
  logic                    y_ovf;
  logic signed [31:0]      y_new;

  always_comb begin
    acc_rnd = (acc + ROUND_Y) >>> 16;
    y_ovf   = !((&acc_rnd[ACC_W-1:31]) || !(|acc_rnd[ACC_W-1:31]));
    if (y_ovf) begin
      y_new = acc_rnd[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      y_new = acc_rnd[31:0];
    end
  end

  // Crossing test and Q8 output from the new y (held in out_prev1).
  logic signed [32:0] y_ext, thr_ext, f_rnd;
  logic               cross_fall, cross_rise, f_ovf;
  logic [17:0]        f_new;
  logic [31:0]        half_now;
  logic [32:0]        period;

  always_comb begin
    y_ext      = {out_prev1[31], out_prev1};
    thr_ext    = $signed({9'd0, threshold_q8, 8'd0});
    cross_fall = above_flag && (y_ext < thr_ext);
    cross_rise = !above_flag && (y_ext > thr_ext);
    f_rnd      = (y_ext + 33'sd128) >>> 8;
    f_ovf      = !((&f_rnd[32:17]) || !(|f_rnd[32:17]));
    if (f_ovf) begin
      f_new = f_rnd[32] ? 18'h20000 : 18'h1ffff;
    end else begin
      f_new = f_rnd[17:0];
    end
    half_now = now_ms - last_cross_time;
    period   = {1'b0, first_half_period} + {1'b0, half_now};
  end

  // Restoring divide step.
  logic [33:0] rem_sh, rem_diff;
  logic        q_bit;
  logic [32:0] rem_next;
  logic [23:0] quo_next;

  always_comb begin
    rem_sh   = {rem, quo[23]};
    rem_diff = rem_sh - {1'b0, divisor};
    q_bit    = (rem_sh >= {1'b0, divisor});
    rem_next = q_bit ? rem_diff[32:0] : rem_sh[32:0];
    quo_next = {quo[22:0], q_bit};
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt == '0) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_CROSS;
      end
      ST_CROSS: begin
        if (cross_rise && (period != '0)) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_q8   <= THRESH_RESET;
      fault_distance <= FAULT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold_q8   <= cfg_data;
        REG_FAULT:     fault_distance <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample       <= '0;
      out_prev1         <= '0;
      out_prev2         <= '0;
      above_flag        <= 1'b1;
      last_cross_time   <= '0;
      first_half_period <= '0;
      rate_reg          <= '0;
    end else begin
      if (state == ST_ROUND) begin
        prev_sample <= x_cur;
        out_prev2   <= out_prev1;
        out_prev1   <= y_new;
      end
      if (state == ST_CROSS) begin
        if (cross_fall) begin
          above_flag        <= 1'b0;
          first_half_period <= half_now;
          last_cross_time   <= now_ms;
        end else if (cross_rise) begin
          above_flag      <= 1'b1;
          last_cross_time <= now_ms;
          if (period == '0) begin
            rate_reg <= RATE_NUM;   // zero period saturates
          end
        end
      end
      if (state == ST_DIV && cnt == '0) begin
        rate_reg <= quo_next;
      end
    end
  end

  // datapath working registers (no reset needed)
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          x_cur  <= s_tuser ? s_tdata[7:0] : fault_distance;
          sh_x   <= s_tuser ? s_tdata[7:0] : fault_distance;
          now_ms <= s_tdata[39:8];
          sh_y1  <= out_prev1;
          sh_y2  <= out_prev2;
          sh_x1  <= prev_sample;
          acc    <= '0;
          cnt    <= MAC_LAST_BIT;
        end
      end
      ST_MAC: begin
        acc   <= acc_next;
        sh_y1 <= {sh_y1[30:0], 1'b0};
        sh_y2 <= {sh_y2[30:0], 1'b0};
        if (x_window) begin
          sh_x  <= {sh_x[6:0], 1'b0};
          sh_x1 <= {sh_x1[6:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
      end
      ST_CROSS: begin
        filt    <= f_new;
        rem     <= '0;
        divisor <= period;
        quo     <= RATE_NUM;
        cnt     <= DIV_LAST_BIT;
      end
      ST_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 5'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {6'd0, rate_reg, filt};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/itrm_checker.sv =====
// Port-level checker for the IIR threshold rate meter, bound to the top level.
`default_nettype none
`include "iir_threshold_rate_meter_assert.svh"
module itrm_checker
  import itrm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  `ITRM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output beat dropped")
  `ITRM_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled beat changed")
  `ITRM_ASSERT(a_rate_max, m_tvalid |-> (m_tdata[41:18] <= RATE_NUM), "rate above bound")
  `ITRM_ASSERT_RST(a_rst_idle, rst |=> !m_tvalid && s_tready, "not idle after reset")

endmodule

bind iir_threshold_rate_meter itrm_checker u_itrm_checker (.*);
`default_nettype wire
